// ===== src/pose_moving_average_macros.svh =====
// Assertion macros shared by the pose moving-average RTL.
// Depends on nothing; included by the top level.
`ifndef POSE_MOVING_AVERAGE_MACROS_SVH
`define POSE_MOVING_AVERAGE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define PMA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define PMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pma_pkg.sv =====
// Package for the pose moving-average filter: field widths, constants and
// width helpers. Depends on nothing.
`timescale 1ns / 1ps

package pma_pkg;

   localparam int POS_BITS           = 32;
   localparam int QUAT_BITS          = 16;
   localparam int TAG_BITS           = 32;
   localparam int WINDOW_BITS        = 7;
   localparam int WINDOW_RESET       = 10;
   localparam int MAX_WINDOW_DEFAULT = 64;
   localparam int Q_FRAC             = 14;
   localparam int ROOT_BITS          = Q_FRAC + 1;
   localparam int QUEUE_DEPTH        = 2;
   localparam int ENTRY_BITS         = 3 * POS_BITS + 4 * QUAT_BITS;

   // Sum width for a field of the given width summed over up to max_window poses.
   function automatic int sum_bits(input int base, input int max_window);
      return base + $clog2(max_window);
   endfunction

   // Width of one job handed from the front to the back.
   function automatic int job_bits(input int max_window);
      return TAG_BITS + 3 * sum_bits(POS_BITS, max_window)
             + 4 * sum_bits(QUAT_BITS, max_window);
   endfunction

endpackage

// ===== src/pma_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module pma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pma_queue.sv =====
// Short register FIFO that decouples the front from the back.
// Depends on nothing.
`timescale 1ns / 1ps

module pma_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNW  = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CNW-1:0]   count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/pma_front.sv =====
// Front of the pose moving-average filter: takes requests, keeps the history
// ring and running sums, and queues a job when the window is full.
// Depends on pma_pkg and pma_ram.
`timescale 1ns / 1ps

module pma_front import pma_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
   localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   localparam int CW  = $clog2(MAX_WINDOW + 1),
   localparam int JW  = job_bits(MAX_WINDOW)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_BITS-1:0]  req_pos_x,
   input  logic signed [POS_BITS-1:0]  req_pos_y,
   input  logic signed [POS_BITS-1:0]  req_pos_z,
   input  logic signed [QUAT_BITS-1:0] req_quat_x,
   input  logic signed [QUAT_BITS-1:0] req_quat_y,
   input  logic signed [QUAT_BITS-1:0] req_quat_z,
   input  logic signed [QUAT_BITS-1:0] req_quat_w,
   input  logic [TAG_BITS-1:0]         req_time_tag,
   input  logic                        csr_write,
   input  logic [WINDOW_BITS-1:0]      csr_window_size,
   output logic [CW-1:0]               win_size,
   output logic                        job_push,
   output logic [JW-1:0]               job_data,
   input  logic                        job_full,
   output logic                        idle
);

   localparam int PSW = sum_bits(POS_BITS, MAX_WINDOW);
   localparam int QSW = sum_bits(QUAT_BITS, MAX_WINDOW);
   localparam int EW  = (CW > WINDOW_BITS) ? CW : WINDOW_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_PUSH
   } state_type;

   state_type                 state_ff;
   logic [WINDOW_BITS-1:0]    ws_ff;
   logic [CW-1:0]             fill_ff;
   logic [AW-1:0]             wi_ff;
   logic                      full_ff;
   logic signed [PSW-1:0]     psum_ff [3];
   logic signed [QSW-1:0]     qsum_ff [4];
   logic [ENTRY_BITS-1:0]     entry_ff;
   logic [TAG_BITS-1:0]       tag_ff;

   logic signed [PSW-1:0]     psum_in [3];
   logic signed [QSW-1:0]     qsum_in [4];
   logic [CW-1:0]             fill_in;
   logic [EW-1:0]             ws_ext;
   logic [EW-1:0]             win_ext;
   logic [CW:0]               old_ext;
   logic [AW-1:0]             old_addr;
   logic [ENTRY_BITS-1:0]     old_entry;
   logic                      accept;

   // Effective window: zero means one, anything above the ring depth saturates.
   always_comb begin
      ws_ext = EW'(ws_ff);
      if (ws_ext == '0) begin
         win_ext = EW'(1);
      end else if (ws_ext > EW'(MAX_WINDOW)) begin
         win_ext = EW'(MAX_WINDOW);
      end else begin
         win_ext = ws_ext;
      end
   end
   assign win_size = CW'(win_ext);

   // Oldest entry sits fill_count places behind the write index.
   always_comb begin
      if ((CW + 1)'(wi_ff) >= (CW + 1)'(fill_ff)) begin
         old_ext = (CW + 1)'(wi_ff) - (CW + 1)'(fill_ff);
      end else begin
         old_ext = (CW + 1)'(wi_ff) + (CW + 1)'(MAX_WINDOW) - (CW + 1)'(fill_ff);
      end
      old_addr = AW'(old_ext);
   end

   pma_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPDATE),
      .wr_addr (wi_ff),
      .wr_data (entry_ff),
      .rd_addr (old_addr),
      .rd_data (old_entry)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         psum_in[i] = psum_ff[i]
            + PSW'($signed(entry_ff[i*POS_BITS +: POS_BITS]))
            - (full_ff ? PSW'($signed(old_entry[i*POS_BITS +: POS_BITS])) : '0);
      end
      for (int j = 0; j < 4; j++) begin
         qsum_in[j] = qsum_ff[j]
            + QSW'($signed(entry_ff[3*POS_BITS + j*QUAT_BITS +: QUAT_BITS]))
            - (full_ff ? QSW'($signed(old_entry[3*POS_BITS + j*QUAT_BITS +: QUAT_BITS]))
                       : '0);
      end
      fill_in = full_ff ? fill_ff : fill_ff + 1'b1;
   end

   // A window write clears the history, so no request is taken in that cycle.
   assign accept    = req_valid && (state_ff == ST_IDLE) && !csr_write;
   assign req_stall = (state_ff != ST_IDLE) || csr_write;
   assign idle      = (state_ff == ST_IDLE);
   assign job_push  = (state_ff == ST_PUSH) && !job_full;

   always_comb begin
      job_data = '0;
      for (int i = 0; i < 3; i++) begin
         job_data[i*PSW +: PSW] = psum_ff[i];
      end
      for (int j = 0; j < 4; j++) begin
         job_data[3*PSW + j*QSW +: QSW] = qsum_ff[j];
      end
      job_data[JW-1 -: TAG_BITS] = tag_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= {req_quat_w, req_quat_z, req_quat_y, req_quat_x,
                      req_pos_z, req_pos_y, req_pos_x};
         tag_ff   <= req_time_tag;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         ws_ff    <= WINDOW_BITS'(WINDOW_RESET);
         fill_ff  <= '0;
         wi_ff    <= '0;
         full_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) psum_ff[i] <= '0;
         for (int j = 0; j < 4; j++) qsum_ff[j] <= '0;
      end else if (csr_write) begin
         ws_ff   <= csr_window_size;
         fill_ff <= '0;
         wi_ff   <= '0;
         for (int i = 0; i < 3; i++) psum_ff[i] <= '0;
         for (int j = 0; j < 4; j++) qsum_ff[j] <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  full_ff  <= (EW'(fill_ff) == win_ext);
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               psum_ff <= psum_in;
               qsum_ff <= qsum_in;
               fill_ff <= fill_in;
               wi_ff   <= (wi_ff == AW'(MAX_WINDOW - 1)) ? '0 : wi_ff + 1'b1;
               state_ff <= (EW'(fill_in) == win_ext) ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH: begin
               if (!job_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/pma_back.sv =====
// Back of the pose moving-average filter: divides the position sums by the
// window and normalizes the quaternion sum, then holds the response.
// Depends on pma_pkg.
`timescale 1ns / 1ps

module pma_back import pma_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
   localparam int CW  = $clog2(MAX_WINDOW + 1),
   localparam int JW  = job_bits(MAX_WINDOW)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CW-1:0]               win_size,
   input  logic                        job_valid,
   input  logic [JW-1:0]               job_data,
   output logic                        job_pop,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [POS_BITS-1:0]  rsp_mean_x,
   output logic signed [POS_BITS-1:0]  rsp_mean_y,
   output logic signed [POS_BITS-1:0]  rsp_mean_z,
   output logic signed [QUAT_BITS-1:0] rsp_norm_qx,
   output logic signed [QUAT_BITS-1:0] rsp_norm_qy,
   output logic signed [QUAT_BITS-1:0] rsp_norm_qz,
   output logic signed [QUAT_BITS-1:0] rsp_norm_qw,
   output logic [TAG_BITS-1:0]         rsp_out_tag,
   output logic                        rsp_degenerate
);

   localparam int PSW    = sum_bits(POS_BITS, MAX_WINDOW);
   localparam int QSW    = sum_bits(QUAT_BITS, MAX_WINDOW);
   localparam int SQW    = 2 * QSW;
   localparam int SSW    = SQW + 2;
   localparam int RSHIFT = 2 * Q_FRAC + 2;
   localparam int NW     = SSW + 2 * ROOT_BITS + 2;
   localparam int KW     = $clog2(ROOT_BITS);
   localparam int SHW    = KW + 2;
   localparam int DCW    = $clog2(PSW + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SETUP,
      ST_ROOT,
      ST_DRAIN
   } state_type;

   state_type              state_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic                   qneg_ff  [4];
   logic [QSW-1:0]         qmag_ff  [4];
   logic [SQW-1:0]         sq_ff    [4];
   logic [SSW-1:0]         ss_ff;
   logic signed [NW-1:0]   acc_a_ff [4];
   logic signed [NW-1:0]   acc_b_ff [4];
   logic [ROOT_BITS-1:0]   root_ff  [4];
   logic [KW-1:0]          bit_ff;
   logic [PSW-1:0]         dq_ff    [3];
   logic [CW-1:0]          rem_ff   [3];
   logic                   pneg_ff  [3];
   logic [DCW-1:0]         div_cnt_ff;
   logic                   rsp_valid_ff;
   logic [POS_BITS-1:0]    mean_ff  [3];
   logic [QUAT_BITS-1:0]   norm_ff  [4];
   logic [TAG_BITS-1:0]    out_tag_ff;
   logic                   degen_ff;

   logic signed [PSW-1:0]  job_p    [3];
   logic signed [QSW-1:0]  job_q    [4];
   logic signed [NW-1:0]   ss_s;
   logic signed [NW-1:0]   cand     [4];
   logic signed [NW-1:0]   b_in     [4];
   logic signed [NW-1:0]   r_lim    [4];
   logic                   take     [4];
   logic [SHW-1:0]         sh_b;
   logic [SHW-1:0]         sh_c;
   logic [SHW-1:0]         sh_d;
   logic [CW:0]            rem2     [3];
   logic                   fit      [3];
   logic [PSW-1:0]         neg_q    [3];
   logic                   out_free;
   logic                   degen;
   logic                   launch;

   always_comb begin
      for (int i = 0; i < 3; i++) job_p[i] = $signed(job_data[i*PSW +: PSW]);
      for (int j = 0; j < 4; j++) job_q[j] = $signed(job_data[3*PSW + j*QSW +: QSW]);
   end

   // Root search: the digit is kept while (2m-1)^2 * ss <= s^2 * 2^30.
   // A holds (2m-1)^2 * ss and B holds (2m-1) * ss, both updated by shifts.
   always_comb begin
      ss_s = $signed(NW'(ss_ff));
      sh_b = SHW'(bit_ff) + SHW'(2);
      sh_c = SHW'({bit_ff, 1'b0}) + SHW'(2);
      sh_d = SHW'(bit_ff) + SHW'(1);
      for (int j = 0; j < 4; j++) begin
         r_lim[j] = $signed(NW'({sq_ff[j], {RSHIFT{1'b0}}}));
         cand[j]  = acc_a_ff[j] + (acc_b_ff[j] <<< sh_b) + (ss_s <<< sh_c);
         b_in[j]  = acc_b_ff[j] + (ss_s <<< sh_d);
         take[j]  = !root_ff[j][ROOT_BITS-1] && (cand[j] <= r_lim[j]);
      end
   end

   // Restoring division of each position magnitude by the window, one bit a cycle.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem2[i]  = {rem_ff[i], dq_ff[i][PSW-1]};
         fit[i]   = (rem2[i] >= (CW + 1)'(win_size));
         neg_q[i] = '0 - dq_ff[i];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign degen    = (ss_ff == '0);
   assign launch   = (state_ff == ST_DRAIN) && (div_cnt_ff == '0) && out_free;
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;
   assign busy     = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (launch) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= fit[i] ? CW'(rem2[i] - (CW + 1)'(win_size)) : CW'(rem2[i]);
               dq_ff[i]  <= {dq_ff[i][PSW-2:0], fit[i]};
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  tag_ff <= job_data[JW-1 -: TAG_BITS];
                  for (int i = 0; i < 3; i++) begin
                     pneg_ff[i] <= job_p[i][PSW-1];
                     dq_ff[i]   <= job_p[i][PSW-1] ? PSW'(-job_p[i]) : PSW'(job_p[i]);
                     rem_ff[i]  <= '0;
                  end
                  for (int j = 0; j < 4; j++) begin
                     qneg_ff[j] <= job_q[j][QSW-1];
                     qmag_ff[j] <= job_q[j][QSW-1] ? QSW'(-job_q[j]) : QSW'(job_q[j]);
                  end
                  div_cnt_ff <= DCW'(PSW);
                  state_ff   <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               for (int j = 0; j < 4; j++) begin
                  sq_ff[j] <= qmag_ff[j] * qmag_ff[j];
               end
               state_ff <= ST_SETUP;
            end
            ST_SETUP: begin
               ss_ff <= SSW'(sq_ff[0]) + SSW'(sq_ff[1]) + SSW'(sq_ff[2]) + SSW'(sq_ff[3]);
               // Start from m = 0, where 2m-1 = -1.
               for (int j = 0; j < 4; j++) begin
                  acc_a_ff[j] <= $signed(NW'(SSW'(sq_ff[0]) + SSW'(sq_ff[1])
                                             + SSW'(sq_ff[2]) + SSW'(sq_ff[3])));
                  acc_b_ff[j] <= -$signed(NW'(SSW'(sq_ff[0]) + SSW'(sq_ff[1])
                                              + SSW'(sq_ff[2]) + SSW'(sq_ff[3])));
                  root_ff[j]  <= '0;
               end
               bit_ff   <= KW'(ROOT_BITS - 1);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               for (int j = 0; j < 4; j++) begin
                  if (take[j]) begin
                     acc_a_ff[j]         <= cand[j];
                     acc_b_ff[j]         <= b_in[j];
                     root_ff[j][bit_ff]  <= 1'b1;
                  end
               end
               if (bit_ff == '0) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            ST_DRAIN: begin
               if (launch) begin
                  out_tag_ff   <= tag_ff;
                  degen_ff     <= degen;
                  for (int i = 0; i < 3; i++) begin
                     mean_ff[i] <= pneg_ff[i] ? neg_q[i][POS_BITS-1:0]
                                              : dq_ff[i][POS_BITS-1:0];
                  end
                  for (int j = 0; j < 4; j++) begin
                     if (degen) begin
                        norm_ff[j] <= '0;
                     end else if (qneg_ff[j]) begin
                        norm_ff[j] <= '0 - QUAT_BITS'(root_ff[j]);
                     end else begin
                        norm_ff[j] <= QUAT_BITS'(root_ff[j]);
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_x     = $signed(mean_ff[0]);
   assign rsp_mean_y     = $signed(mean_ff[1]);
   assign rsp_mean_z     = $signed(mean_ff[2]);
   assign rsp_norm_qx    = $signed(norm_ff[0]);
   assign rsp_norm_qy    = $signed(norm_ff[1]);
   assign rsp_norm_qz    = $signed(norm_ff[2]);
   assign rsp_norm_qw    = $signed(norm_ff[3]);
   assign rsp_out_tag    = out_tag_ff;
   assign rsp_degenerate = degen_ff;

endmodule

// ===== src/pose_moving_average.sv =====
// Top level of the pose moving-average filter with quaternion normalization.
// Depends on pma_pkg, pma_front, pma_queue, pma_back and the assertion macros.
//
//   channel   direction  handshake              carries
//   req_      in         req_valid / req_stall  one pose and its time tag
//   rsp_      out        rsp_valid / rsp_stall  mean position, unit quaternion, tag
//   csr_      in         csr_valid / csr_ready  window_size write data
//
// In the front a request passes a ring read, then the sum update and ring write,
// and, if it completes a window, a push into the job queue that waits while full.
// The back runs the bit-serial window divider and the 15-step root search side by
// side for each job, and takes no new job until its response is launched.
// Reset is synchronous and clears control state; the ring is not cleared.
// Either side may stall at any time; the queue and the response register
// let the front keep taking requests while a response waits.
`timescale 1ns / 1ps

module pose_moving_average import pma_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_BITS-1:0]  req_pos_x,
   input  logic signed [POS_BITS-1:0]  req_pos_y,
   input  logic signed [POS_BITS-1:0]  req_pos_z,
   input  logic signed [QUAT_BITS-1:0] req_quat_x,
   input  logic signed [QUAT_BITS-1:0] req_quat_y,
   input  logic signed [QUAT_BITS-1:0] req_quat_z,
   input  logic signed [QUAT_BITS-1:0] req_quat_w,
   input  logic [TAG_BITS-1:0]         req_time_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [POS_BITS-1:0]  rsp_mean_x,
   output logic signed [POS_BITS-1:0]  rsp_mean_y,
   output logic signed [POS_BITS-1:0]  rsp_mean_z,
   output logic signed [QUAT_BITS-1:0] rsp_norm_qx,
   output logic signed [QUAT_BITS-1:0] rsp_norm_qy,
   output logic signed [QUAT_BITS-1:0] rsp_norm_qz,
   output logic signed [QUAT_BITS-1:0] rsp_norm_qw,
   output logic [TAG_BITS-1:0]         rsp_out_tag,
   output logic                        rsp_degenerate,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [WINDOW_BITS-1:0]      csr_window_size
);

`include "pose_moving_average_macros.svh"

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int JW = job_bits(MAX_WINDOW);

   logic [CW-1:0] win_size;
   logic          job_push;
   logic [JW-1:0] job_in;
   logic [JW-1:0] job_out;
   logic          q_full;
   logic          q_empty;
   logic          job_pop;
   logic          front_idle;
   logic          back_busy;
   logic          csr_write;

   // The window register is only rewritten with nothing in flight, so the
   // history clear cannot race a request that is still being worked on.
   assign csr_ready = front_idle && q_empty && !back_busy && !rsp_valid;
   assign csr_write = csr_valid && csr_ready;

   // Front: ring, fill count and running sums.
   pma_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_quat_x      (req_quat_x),
      .req_quat_y      (req_quat_y),
      .req_quat_z      (req_quat_z),
      .req_quat_w      (req_quat_w),
      .req_time_tag    (req_time_tag),
      .csr_write       (csr_write),
      .csr_window_size (csr_window_size),
      .win_size        (win_size),
      .job_push        (job_push),
      .job_data        (job_in),
      .job_full        (q_full),
      .idle            (front_idle)
   );

   // Jobs carry a snapshot of the sums and the tag of the newest request.
   pma_queue #(
      .WIDTH (JW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: window divide, root search and the response register.
   pma_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .win_size       (win_size),
      .job_valid      (!q_empty),
      .job_data       (job_out),
      .job_pop        (job_pop),
      .busy           (back_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_x     (rsp_mean_x),
      .rsp_mean_y     (rsp_mean_y),
      .rsp_mean_z     (rsp_mean_z),
      .rsp_norm_qx    (rsp_norm_qx),
      .rsp_norm_qy    (rsp_norm_qy),
      .rsp_norm_qz    (rsp_norm_qz),
      .rsp_norm_qw    (rsp_norm_qw),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_degenerate (rsp_degenerate)
   );

   // A job is never offered to a full queue nor taken from an empty one.
   `PMA_ASSERT_ALWAYS(a_no_push_full, clock, reset, !(job_push && q_full), "push into full queue")
   `PMA_ASSERT_ALWAYS(a_no_pop_empty, clock, reset, !(job_pop && q_empty), "pop from empty queue")
   // A window write leaves no response behind it.
   `PMA_ASSERT_NEXT(a_csr_quiet, clock, reset, csr_write, !rsp_valid && !job_push, "csr write not quiet")

endmodule

// ===== tb/pose_moving_average_tb.sv =====
// Testbench for pose_moving_average: drives poses through the request channel,
// predicts each windowed mean and normalized quaternion, and checks every response.
// Depends on pma_pkg and the pose_moving_average RTL.
`timescale 1ns / 1ps

module pose_moving_average_tb;
   import pma_pkg::*;

   localparam int RING_DEPTH   = MAX_WINDOW_DEFAULT;
   localparam int UNIT_Q       = 1 << Q_FRAC;
   localparam int SETTLE_TICKS = 80;
   localparam int MAX_REPORTS  = 10;
   localparam int DUE_DEPTH    = 64;

   // One pose as it enters the request channel.
   typedef struct packed {
      logic signed [POS_BITS-1:0]  px, py, pz;
      logic signed [QUAT_BITS-1:0] qx, qy, qz, qw;
      logic [TAG_BITS-1:0]         tag;
   } pose_req_t;

   // One filtered pose as it leaves the response channel.
   typedef struct packed {
      logic signed [POS_BITS-1:0]  mx, my, mz;
      logic signed [QUAT_BITS-1:0] qx, qy, qz, qw;
      logic [TAG_BITS-1:0]         tag;
      logic                        degen;
   } pose_avg_t;

   // A directed row: the pose, and where it is obvious, the filtered pose typed in.
   typedef struct {
      pose_req_t pose;
      bit        typed;
      pose_avg_t avg;
   } directed_row_t;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [POS_BITS-1:0]  req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [QUAT_BITS-1:0] req_quat_x = '0, req_quat_y = '0;
   logic signed [QUAT_BITS-1:0] req_quat_z = '0, req_quat_w = '0;
   logic [TAG_BITS-1:0]         req_time_tag = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [POS_BITS-1:0]  rsp_mean_x, rsp_mean_y, rsp_mean_z;
   logic signed [QUAT_BITS-1:0] rsp_norm_qx, rsp_norm_qy, rsp_norm_qz, rsp_norm_qw;
   logic [TAG_BITS-1:0]         rsp_out_tag;
   logic                        rsp_degenerate;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [WINDOW_BITS-1:0]      csr_window_size = '0;

   always #5 clock = ~clock;

   pose_moving_average u_dut (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_pos_x, .req_pos_y, .req_pos_z,
      .req_quat_x, .req_quat_y, .req_quat_z, .req_quat_w,
      .req_time_tag,
      .rsp_valid, .rsp_stall,
      .rsp_mean_x, .rsp_mean_y, .rsp_mean_z,
      .rsp_norm_qx, .rsp_norm_qy, .rsp_norm_qz, .rsp_norm_qw,
      .rsp_out_tag, .rsp_degenerate,
      .csr_valid, .csr_ready, .csr_window_size
   );

   // ---------------------------------------------------------------------------
   // Shadow of the filter state. The ring holds the last poses in arrival
   // order; the sums are kept wide enough that they never wrap.
   // ---------------------------------------------------------------------------
   longint                 hist_pos [RING_DEPTH][3];
   longint                 hist_quat[RING_DEPTH][4];
   int unsigned            held_poses;
   int unsigned            next_slot;
   longint                 pos_total [3];
   longint                 quat_total[4];
   logic [WINDOW_BITS-1:0] window_reg;

   // Responses that are due, oldest at the head.
   pose_avg_t   due_ring[DUE_DEPTH];
   int          due_head = 0;
   int          due_tail = 0;
   int          mismatches;
   int          responses_seen;
   int          degenerate_seen;
   int          requests_sent;
   bit          calm;             // when set, neither side idles or stalls
   pose_req_t   last_pose;

   function automatic int due_count();
      return due_tail - due_head;
   endfunction

   task automatic clear_history();
      held_poses = 0;
      next_slot  = 0;
      foreach (pos_total[i]) pos_total[i] = 0;
      foreach (quat_total[i]) quat_total[i] = 0;
   endtask

   // round(|s| * 2^14 / sqrt(ss)), found as the largest m with
   // (2m - 1)^2 * ss <= s^2 * 2^30, which is the rounding test squared.
   function automatic longint unsigned unit_magnitude(longint unsigned s,
                                                      longint unsigned ss);
      logic [127:0]    limit;
      logic [127:0]    lhs;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned odd;
      limit = 128'(s * s) << 30;
      lo = 0;
      hi = UNIT_Q;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         odd = 2 * mid - 1;
         lhs = 128'(odd * odd) * 128'(ss);
         if (lhs <= limit) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // Advance the shadow by one accepted pose; returns 1 when a response is due.
   function automatic bit filter_pose(input pose_req_t p, output pose_avg_t avg);
      int unsigned     span;
      int unsigned     oldest;
      longint          np[3];
      longint          nq[4];
      longint unsigned mag[4];
      longint unsigned ss;
      longint          m;
      span = (window_reg == 0) ? 1 : ((window_reg > RING_DEPTH) ? RING_DEPTH : window_reg);
      np = '{longint'(p.px), longint'(p.py), longint'(p.pz)};
      nq = '{longint'(p.qx), longint'(p.qy), longint'(p.qz), longint'(p.qw)};
      if (held_poses >= span) begin
         oldest = (next_slot + RING_DEPTH - held_poses) % RING_DEPTH;
         for (int i = 0; i < 3; i++) pos_total[i] -= hist_pos[oldest][i];
         for (int i = 0; i < 4; i++) quat_total[i] -= hist_quat[oldest][i];
         held_poses--;
      end
      for (int i = 0; i < 3; i++) hist_pos[next_slot][i] = np[i];
      for (int i = 0; i < 4; i++) hist_quat[next_slot][i] = nq[i];
      next_slot = (next_slot + 1) % RING_DEPTH;
      held_poses++;
      for (int i = 0; i < 3; i++) pos_total[i] += np[i];
      for (int i = 0; i < 4; i++) quat_total[i] += nq[i];
      avg = '{default: '0};
      if (held_poses < span) return 1'b0;

      // Signed division truncates toward zero, as the mean requires.
      avg.mx = POS_BITS'(pos_total[0] / longint'(held_poses));
      avg.my = POS_BITS'(pos_total[1] / longint'(held_poses));
      avg.mz = POS_BITS'(pos_total[2] / longint'(held_poses));
      ss = 0;
      for (int i = 0; i < 4; i++) ss += longint'(quat_total[i] * quat_total[i]);
      avg.degen = (ss == 0);
      if (ss != 0) begin
         for (int i = 0; i < 4; i++) begin
            m = longint'(unit_magnitude((quat_total[i] < 0) ? -quat_total[i] : quat_total[i],
                                        ss));
            mag[i] = (quat_total[i] < 0) ? -m : m;
         end
         avg.qx = QUAT_BITS'(mag[0]);
         avg.qy = QUAT_BITS'(mag[1]);
         avg.qz = QUAT_BITS'(mag[2]);
         avg.qw = QUAT_BITS'(mag[3]);
      end
      avg.tag = p.tag;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side. Every pose is driven at a rising edge and held until the
   // block takes it; valid only drops when a gap follows.
   // ---------------------------------------------------------------------------
   task automatic send_pose(input pose_req_t p, input bit typed, input pose_avg_t typed_avg);
      pose_avg_t avg;
      int        gap;
      req_pos_x    <= p.px;
      req_pos_y    <= p.py;
      req_pos_z    <= p.pz;
      req_quat_x   <= p.qx;
      req_quat_y   <= p.qy;
      req_quat_z   <= p.qz;
      req_quat_w   <= p.qw;
      req_time_tag <= p.tag;
      req_valid    <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // The request was taken at this edge.
      if (filter_pose(p, avg)) begin
         due_ring[due_tail % DUE_DEPTH] = typed ? typed_avg : avg;
         due_tail++;
      end
      last_pose = p;
      requests_sent++;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for every response that is due, then long enough for a request
   // that completed no window to drain out of the front.
   task automatic drain();
      while (due_count() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_BITS-1:0] size);
      go_quiet();
      drain();
      csr_window_size <= size;
      csr_valid       <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      window_reg  = size;
      clear_history();
   endtask

   // Draws a pose. The quaternion comes in several flavors so that sums
   // cancel now and then and the degenerate case shows up in short windows.
   function automatic pose_req_t random_pose();
      pose_req_t p;
      int        flavor;
      p.px  = $urandom();
      p.py  = $urandom();
      p.pz  = $urandom();
      p.tag = $urandom();
      case ($urandom_range(0, 3))
         0: begin
            p.px = $signed(16'($urandom())) * 65536;
            p.py = POS_BITS'($signed(12'($urandom())));
         end
         1: begin
            p.pz = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         end
         default: ;
      endcase
      flavor = $urandom_range(0, 9);
      case (flavor)
         0, 1, 2: begin
            p.qx = QUAT_BITS'($urandom());
            p.qy = QUAT_BITS'($urandom());
            p.qz = QUAT_BITS'($urandom());
            p.qw = QUAT_BITS'($urandom());
         end
         3, 4: begin
            // Close to a unit quaternion, with small jitter.
            p.qx = QUAT_BITS'($signed(8'($urandom())));
            p.qy = QUAT_BITS'($signed(8'($urandom())));
            p.qz = QUAT_BITS'($signed(8'($urandom())));
            p.qw = QUAT_BITS'($urandom_range(0, 1) ? UNIT_Q : -UNIT_Q);
         end
         5: begin
            p.qx = '0; p.qy = '0; p.qz = '0; p.qw = '0;
         end
         6, 7: begin
            // The opposite of the last pose, which cancels it in a window of two.
            p.qx = -last_pose.qx;
            p.qy = -last_pose.qy;
            p.qz = -last_pose.qz;
            p.qw = -last_pose.qw;
         end
         default: begin
            p.qx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            p.qy = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            p.qz = $urandom_range(0, 1) ? 16'sh0000 : 16'sh8000;
            p.qw = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh0001;
         end
      endcase
      return p;
   endfunction

   task automatic random_run(input int count);
      pose_avg_t none;
      none = '{default: '0};
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
         send_pose(random_pose(), 1'b0, none);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response side: stalls for a random count before each response, then
   // checks the response against the oldest expectation.
   // ---------------------------------------------------------------------------
   initial begin
      int hold;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      pose_avg_t want;
      pose_avg_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_mean_x, rsp_mean_y, rsp_mean_z, rsp_norm_qx, rsp_norm_qy,
                 rsp_norm_qz, rsp_norm_qw, rsp_out_tag, rsp_degenerate};
         responses_seen++;
         if (got.degen) degenerate_seen++;
         if (due_count() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: response with tag %h arrived with none expected", got.tag);
         end else begin
            want = due_ring[due_head % DUE_DEPTH];
            due_head++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("ERROR: response mismatch at %0t", $realtime);
                  $display("  expected mean %h %h %h q %h %h %h %h tag %h degen %b",
                           want.mx, want.my, want.mz, want.qx, want.qy, want.qz,
                           want.qw, want.tag, want.degen);
                  $display("  actual   mean %h %h %h q %h %h %h %h tag %h degen %b",
                           got.mx, got.my, got.mz, got.qx, got.qy, got.qz,
                           got.qw, got.tag, got.degen);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------------
   directed_row_t extremes[] = '{
      // Largest positions, one quaternion axis at unit value.
      '{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh4000, 0, 0, 0, 32'hFFFF_FFFF},
        1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh4000, 0, 0, 0,
             32'hFFFF_FFFF, 1'b0}},
      // Smallest positions, the most negative quaternion part.
      '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 16'sh8000, 32'h0},
        1, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, -16'sd16384,
             32'h0, 1'b0}},
      // A zero quaternion is flagged degenerate.
      '{'{0, 0, 0, 0, 0, 0, 0, 32'h1234_5678},
        1, '{0, 0, 0, 0, 0, 0, 0, 32'h1234_5678, 1'b1}},
      // Four equal parts normalize to one half each.
      '{'{1, -1, 32'sh5555_5555, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hAAAA_AAAA},
        1, '{1, -1, 32'sh5555_5555, 16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000,
             32'hAAAA_AAAA, 1'b0}},
      '{'{-2, 2, 32'shAAAA_AAAA, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'h5555_5555},
        1, '{-2, 2, 32'shAAAA_AAAA, -16'sd8192, -16'sd8192, -16'sd8192, -16'sd8192,
             32'h5555_5555, 1'b0}},
      // A 3-4-5 triangle rounds down on both parts.
      '{'{7, 8, 9, 16'sd3000, 16'sd4000, 0, 0, 32'd7},
        1, '{7, 8, 9, 16'sd9830, 16'sd13107, 0, 0, 32'd7, 1'b0}},
      '{'{0, 0, 0, 0, 16'sd1, 0, 0, 32'd8},
        1, '{0, 0, 0, 0, 16'sh4000, 0, 0, 32'd8, 1'b0}},
      '{'{100, -200, 300, 16'sd100, -16'sd200, 16'sd300, -16'sd400, 32'd9}, 0, '{default: '0}},
      '{'{-65536, 65535, 3, 16'sd1, 16'sd1, 16'sd1, 16'sd2, 32'd10}, 0, '{default: '0}}
   };

   initial begin
      pose_avg_t none;
      none            = '{default: '0};
      mismatches      = 0;
      responses_seen  = 0;
      degenerate_seen = 0;
      requests_sent   = 0;
      calm            = 1'b0;
      last_pose       = '{default: '0};
      window_reg      = WINDOW_BITS'(WINDOW_RESET);
      clear_history();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset the window is ten poses long.
      random_run(25);

      // Directed rows with a one-pose window, where each response carries its request's position and tag.
      write_window(1);
      foreach (extremes[i]) send_pose(extremes[i].pose, extremes[i].typed, extremes[i].avg);

      // A zero size acts as one; sizes above the ring saturate to it.
      write_window(0);
      random_run(60);
      write_window(7'h7F);
      random_run(140);

      // The sender holds off here until every pending response has come back.
      go_quiet();
      while (due_count() != 0) @(posedge clock);
      random_run(20);

      write_window(2);
      random_run(140);
      write_window(WINDOW_BITS'(RING_DEPTH));
      random_run(130);
      write_window(WINDOW_BITS'(WINDOW_RESET));
      random_run(80);
      write_window(WINDOW_BITS'(WINDOW_RESET));
      random_run(30);
      for (int k = 0; k < 3; k++) begin
         write_window(WINDOW_BITS'($urandom_range(3, 12)));
         random_run(60);
      end

      go_quiet();
      drain();
      $display("Sent %0d poses over window sizes 0 to 127; checked %0d responses,",
               requests_sent, responses_seen);
      $display("%0d of them degenerate, with %0d mismatches.", degenerate_seen, mismatches);
      if (mismatches == 0 && due_count() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("ERROR: run timed out with %0d responses pending", due_count());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/pma_pkg.sv
src/pma_ram.sv
src/pma_queue.sv
src/pma_front.sv
src/pma_back.sv
src/pose_moving_average.sv
tb/pose_moving_average_tb.sv
